>>> rtl/stts_pkg.sv
// Package for the schedule time table search block.
// Holds field widths, opcode and status codes, and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stts_pkg;

  localparam int unsigned ID_W      = 64;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DEF_SLOTS = 16;
  localparam int unsigned DEF_TIMES = 32;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NOID = 2'd2,
    ST_OVER = 2'd3
  } status_e;

  typedef struct packed {
    logic    capture;
    logic    scan_start;
    logic    scan_en;
    logic    load_start;
    logic    load_write;
    logic    remove_slot;
    logic    walk_start;
    logic    walk_en;
    logic    query_done;
    logic    set_status;
    status_e status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic       id_zero;
    logic [1:0] op;
    logic       load_active;
    logic       chk_match;
    logic       chk_free;
    logic       chk_last;
    logic       walk_stop;
    logic       walk_last;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/stts_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on stts_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface stts_in_if import stts_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [ID_W-1:0]   sched_id;
  logic [TIME_W-1:0] time_value;
  logic              time_last;
  logic [TIME_W-1:0] current_time;

  modport source (
    output valid, opcode, sched_id, time_value, time_last, current_time,
    input  ready
  );
  modport sink (
    input  valid, opcode, sched_id, time_value, time_last, current_time,
    output ready
  );
endinterface

interface stts_out_if import stts_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [TIME_W-1:0] prev_time;
  logic [TIME_W-1:0] next_time;

  modport source (
    output valid, status, prev_time, next_time,
    input  ready
  );
  modport sink (
    input  valid, status, prev_time, next_time,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/stts_ctrl.sv
// Controller state machine: sequences decode, slot scan, time walk and result beat.
// Depends on stts_pkg for cmd_t, sts_t and the code enums.
`timescale 1ns / 1ps
`default_nettype none

module stts_ctrl import stts_pkg::*; (
  input  var logic clk_i,
  input  var logic rst_ni,
  input  var logic in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  var logic out_ready_i,
  input  var sts_t sts_i,
  output cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_LOAD_WR,
    S_WALK,
    S_QRES,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   hit_q, hit_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    cmd_o.status = ST_OK;
    state_d     = state_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.id_zero) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NOID;
          state_d          = S_FINISH;
        end else if (sts_i.op == OP_LOAD) begin
          if (sts_i.load_active) begin
            cmd_o.load_write = 1'b1;
            state_d          = S_FINISH;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
        end else if (sts_i.op == OP_REMOVE) begin
          cmd_o.scan_start = 1'b1;
          hit_d            = 1'b0;
          state_d          = S_SCAN;
        end else if (sts_i.op == OP_QUERY) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_OK;
          state_d          = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.op == OP_LOAD) begin
          if (sts_i.chk_match || sts_i.chk_free) begin
            cmd_o.load_start = 1'b1;
            state_d          = S_LOAD_WR;
          end else if (sts_i.chk_last) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_FULL;
            state_d          = S_FINISH;
          end
        end else if (sts_i.op == OP_REMOVE) begin
          if (sts_i.chk_match) begin
            cmd_o.remove_slot = 1'b1;
            hit_d             = 1'b1;
          end
          if (sts_i.chk_last) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = (hit_q || sts_i.chk_match) ? ST_OK : ST_NOID;
            state_d          = S_FINISH;
          end
        end else begin
          if (sts_i.chk_match) begin
            cmd_o.walk_start = 1'b1;
            state_d          = S_WALK;
          end else if (sts_i.chk_last) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_NOID;
            state_d          = S_FINISH;
          end
        end
      end
      S_LOAD_WR: begin
        cmd_o.load_write = 1'b1;
        state_d          = S_FINISH;
      end
      S_WALK: begin
        cmd_o.walk_en = 1'b1;
        if (sts_i.walk_stop || sts_i.walk_last) begin
          state_d = S_QRES;
        end
      end
      S_QRES: begin
        cmd_o.query_done = 1'b1;
        state_d          = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DECODE && !in_ready_o))
    else $error("request accepted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("result dropped before it was taken");

endmodule

`default_nettype wire

>>> rtl/stts_dpath.sv
// Datapath: slot id memory, time memory, fill counts, scan and walk pipelines,
// result and output registers. Depends on stts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stts_dpath import stts_pkg::*; #(
  parameter int unsigned SLOTS = DEF_SLOTS,
  parameter int unsigned TIMES = DEF_TIMES
) (
  input  var logic              clk_i,
  input  var logic              rst_ni,
  input  var cmd_t              cmd_i,
  output sts_t                  sts_o,
  input  var logic [1:0]        opcode_i,
  input  var logic [ID_W-1:0]   sched_id_i,
  input  var logic [TIME_W-1:0] time_value_i,
  input  var logic              time_last_i,
  input  var logic [TIME_W-1:0] current_time_i,
  output logic [1:0]            status_o,
  output logic [TIME_W-1:0]     prev_time_o,
  output logic [TIME_W-1:0]     next_time_o
);

  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned IDX_W  = (TIMES > 1) ? $clog2(TIMES) : 1;
  localparam int unsigned CNT_W  = $clog2(TIMES + 1);
  localparam int unsigned DEPTH  = SLOTS * TIMES;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TIMES - 1);
  localparam logic [CNT_W-1:0]  TIMES_C   = CNT_W'(TIMES);
  localparam logic [ADDR_W-1:0] TIMES_A   = ADDR_W'(TIMES);

  // captured request
  logic [1:0]        op_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] tv_q;
  logic              last_q;
  logic [TIME_W-1:0] now_q;

  // table state
  logic [SLOTS-1:0]  occ_q;
  logic [CNT_W-1:0]  len_q [SLOTS];
  logic              load_active_q;
  logic [SLOT_W-1:0] load_slot_q;
  logic [CNT_W-1:0]  load_count_q;
  logic [ID_W-1:0]   id_mem [SLOTS];
  logic [TIME_W-1:0] time_mem [DEPTH];

  // slot scan
  logic [SLOT_W-1:0] iss_q;
  logic              iss_act_q;
  logic [SLOT_W-1:0] chk_idx_q;
  logic              chk_vld_q;
  logic [ID_W-1:0]   id_rd_q;

  // time walk
  logic [SLOT_W-1:0] sel_q;
  logic [CNT_W-1:0]  wlen_q;
  logic [IDX_W-1:0]  wiss_q;
  logic              wact_q;
  logic [IDX_W-1:0]  wchk_idx_q;
  logic              wchk_vld_q;
  logic [TIME_W-1:0] t_rd_q;
  logic [TIME_W-1:0] p_q, n_q, first_q;

  // result staging and output beat
  status_e           res_status_q;
  logic [TIME_W-1:0] res_prev_q, res_next_q;
  status_e           out_status_q;
  logic [TIME_W-1:0] out_prev_q, out_next_q;

  logic              chk_occ;
  logic [TIME_W-1:0] t_eff;
  logic              w_first, w_gt, w_end;
  logic              can_wr;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign chk_occ = occ_q[chk_idx_q];
  assign t_eff   = (CNT_W'(wchk_idx_q) < wlen_q) ? t_rd_q : '0;
  assign w_first = (wchk_idx_q == '0);
  assign w_gt    = (t_eff > now_q);
  assign w_end   = (t_eff == '0) && !w_first;
  assign can_wr  = (load_count_q < TIMES_C);
  assign wr_addr = ADDR_W'(load_slot_q) * TIMES_A + ADDR_W'(load_count_q[IDX_W-1:0]);
  assign rd_addr = ADDR_W'(sel_q) * TIMES_A + ADDR_W'(wiss_q);

  always_comb begin
    sts_o.id_zero     = (id_q == '0);
    sts_o.op          = op_q;
    sts_o.load_active = load_active_q;
    sts_o.chk_match   = chk_vld_q && chk_occ && (id_rd_q == id_q);
    sts_o.chk_free    = chk_vld_q && !chk_occ;
    sts_o.chk_last    = chk_vld_q && (chk_idx_q == LAST_SLOT);
    sts_o.walk_stop   = wchk_vld_q && (w_gt || w_end);
    sts_o.walk_last   = wchk_vld_q && (wchk_idx_q == LAST_IDX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q         <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        len_q[i] <= '0;
      end
      load_active_q <= 1'b0;
      load_slot_q   <= '0;
      load_count_q  <= '0;
      iss_q         <= '0;
      iss_act_q     <= 1'b0;
      chk_idx_q     <= '0;
      chk_vld_q     <= 1'b0;
      wiss_q        <= '0;
      wact_q        <= 1'b0;
      wchk_idx_q    <= '0;
      wchk_vld_q    <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        iss_q     <= '0;
        iss_act_q <= 1'b1;
        chk_vld_q <= 1'b0;
      end else if (cmd_i.scan_en) begin
        if (iss_act_q) begin
          chk_idx_q <= iss_q;
          chk_vld_q <= 1'b1;
          iss_q     <= iss_q + 1'b1;
          iss_act_q <= (iss_q != LAST_SLOT);
        end else begin
          chk_vld_q <= 1'b0;
        end
      end
      if (cmd_i.walk_start) begin
        wiss_q     <= '0;
        wact_q     <= 1'b1;
        wchk_vld_q <= 1'b0;
      end else if (cmd_i.walk_en) begin
        if (wact_q) begin
          wchk_idx_q <= wiss_q;
          wchk_vld_q <= 1'b1;
          wiss_q     <= wiss_q + 1'b1;
          wact_q     <= (wiss_q != LAST_IDX);
        end else begin
          wchk_vld_q <= 1'b0;
        end
      end
      if (cmd_i.load_start) begin
        load_slot_q      <= chk_idx_q;
        load_count_q     <= '0;
        load_active_q    <= 1'b1;
        occ_q[chk_idx_q] <= 1'b1;
        len_q[chk_idx_q] <= '0;
      end
      if (cmd_i.load_write) begin
        if (can_wr) begin
          len_q[load_slot_q] <= load_count_q + 1'b1;
          load_count_q       <= load_count_q + 1'b1;
        end
        if (last_q) begin
          load_active_q <= 1'b0;
        end
      end
      if (cmd_i.remove_slot) begin
        occ_q[chk_idx_q] <= 1'b0;
        len_q[chk_idx_q] <= '0;
        if (load_active_q && (load_slot_q == chk_idx_q)) begin
          load_active_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      id_q   <= sched_id_i;
      tv_q   <= time_value_i;
      last_q <= time_last_i;
      now_q  <= current_time_i;
    end
    if (cmd_i.walk_start) begin
      sel_q   <= chk_idx_q;
      wlen_q  <= len_q[chk_idx_q];
      p_q     <= '0;
      n_q     <= '0;
      first_q <= '0;
    end else if (cmd_i.walk_en && wchk_vld_q) begin
      if (w_first) begin
        first_q <= t_eff;
      end
      if (w_gt) begin
        n_q <= t_eff;
      end else if (!w_end) begin
        p_q <= t_eff;
      end
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status;
      res_prev_q   <= '0;
      res_next_q   <= '0;
    end else if (cmd_i.load_write) begin
      res_status_q <= can_wr ? ST_OK : ST_OVER;
      res_prev_q   <= '0;
      res_next_q   <= '0;
    end else if (cmd_i.query_done) begin
      res_status_q <= ST_OK;
      res_prev_q   <= (p_q == '0) ? first_q : p_q;
      res_next_q   <= (n_q == '0) ? first_q : n_q;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_prev_q   <= res_prev_q;
      out_next_q   <= res_next_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      id_mem[chk_idx_q] <= id_q;
    end
    if (cmd_i.scan_en && iss_act_q) begin
      id_rd_q <= id_mem[iss_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_write && can_wr) begin
      time_mem[wr_addr] <= tv_q;
    end
    if (cmd_i.walk_en && wact_q) begin
      t_rd_q <= time_mem[rd_addr];
    end
  end

  assign status_o    = out_status_q;
  assign prev_time_o = out_prev_q;
  assign next_time_o = out_next_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_active_q |-> occ_q[load_slot_q])
    else $error("active load targets a free slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_active_q |-> (len_q[load_slot_q] == load_count_q))
    else $error("load count and slot fill count disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_start || cmd_i.remove_slot) |-> chk_vld_q)
    else $error("slot update without a checked slot");

endmodule

`default_nettype wire

>>> rtl/schedule_time_table_search_top.sv
// Top level of the schedule time table search block.
// One request in flight: the slot scan and time walk each check one entry per cycle,
// and the next beat is taken in the cycle after the result loads.
// Reset frees every slot at once through per-slot occupancy and fill counts.
`timescale 1ns / 1ps
`default_nettype none

module schedule_time_table_search_top import stts_pkg::*; #(
  parameter int unsigned SLOTS = DEF_SLOTS,
  parameter int unsigned TIMES = DEF_TIMES
) (
  input  var logic   clk_i,
  input  var logic   rst_ni,
  stts_in_if.sink    in_i,
  stts_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  stts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  stts_dpath #(
    .SLOTS (SLOTS),
    .TIMES (TIMES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (in_i.opcode),
    .sched_id_i     (in_i.sched_id),
    .time_value_i   (in_i.time_value),
    .time_last_i    (in_i.time_last),
    .current_time_i (in_i.current_time),
    .status_o       (out_o.status),
    .prev_time_o    (out_o.prev_time),
    .next_time_o    (out_o.next_time)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

`default_nettype wire
